// File: rtl/core/assert_macros.svh
// Assertion macros shared by the frame builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that pre implies post in the same cycle.
`define CHK_NOW(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Checks that pre implies post in the next cycle.
`define CHK_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/core/ofr_pkg.sv
// Shared types and constants of the orthonormal frame builder.
package ofr_pkg;

  localparam int RED_BITS = 30;
  localparam int SQ_BITS  = 2 * RED_BITS;
  localparam int S_BITS   = SQ_BITS + 2;

  typedef struct packed {
    logic valid;
    logic nonzero;
  } ofr_status_t;

  function automatic int nrm_latency(input int frac);
    return frac + 8;
  endfunction

endpackage

// File: rtl/core/ofr_normalize.sv
// Pipelined exact vector normalization to Q1.FRAC_BITS unit components.
`include "assert_macros.svh"

module ofr_normalize import ofr_pkg::*; #(
  parameter int IW        = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [IW-1:0]        vec  [3],
  output logic signed [FRAC_BITS+1:0] axis [3],
  output ofr_status_t                 stat
);

  localparam int MW  = (IW > RED_BITS) ? IW : RED_BITS;
  localparam int KW  = $clog2(MW + 1);
  localparam int MGW = FRAC_BITS + 1;
  localparam int OW  = FRAC_BITS + 2;
  localparam int RW  = 2 * FRAC_BITS + 68;
  localparam int SST = FRAC_BITS + 1;
  localparam int LAT = nrm_latency(FRAC_BITS);
  localparam logic signed [OW-1:0] LIM = OW'(1) << FRAC_BITS;

  logic              v1, v2, v3, v4, v5;
  logic [MW-1:0]     mag_c [3];
  logic [MW-1:0]     mag1 [3];
  logic [MW-1:0]     mag2 [3];
  logic [MW-1:0]     orv1;
  logic [2:0]        neg_c, neg1, neg2, neg3, neg4, neg5;
  logic [KW-1:0]     k_c, k2;
  logic [RED_BITS-1:0] a3 [3];
  logic [SQ_BITS-1:0]  sq4 [3];
  logic [SQ_BITS-1:0]  sq5 [3];
  logic [S_BITS-1:0]   s5;

  logic signed [RW-1:0] rr [SST+1][3];
  logic signed [RW-1:0] gg [SST+1][3];
  logic [MGW-1:0]       mm [SST+1][3];
  logic [S_BITS-1:0]    ss [SST+1];
  logic [2:0]           ng [SST+1];
  logic                 nzz [SST+1];
  logic                 vv [SST+1];

  always_comb begin
    logic [IW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = vec[i][IW-1];
      t = neg_c[i] ? IW'(-vec[i]) : IW'(vec[i]);
      mag_c[i] = MW'(t);
    end
  end

  always_comb begin
    k_c = '0;
    for (int b = RED_BITS; b < MW; b++) begin
      if (orv1[b]) begin
        k_c = KW'(b - RED_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      vv[0] <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      vv[0] <= v5;
    end
    mag1 <= mag_c;
    neg1 <= neg_c;
    orv1 <= mag_c[0] | mag_c[1] | mag_c[2];
    mag2 <= mag1;
    neg2 <= neg1;
    k2   <= k_c;
    for (int i = 0; i < 3; i++) begin
      a3[i]  <= RED_BITS'(mag2[i] >> k2);
      sq4[i] <= SQ_BITS'(a3[i]) * SQ_BITS'(a3[i]);
    end
    neg3 <= neg2;
    neg4 <= neg3;
    sq5  <= sq4;
    neg5 <= neg4;
    s5   <= S_BITS'(sq4[0]) + S_BITS'(sq4[1]) + S_BITS'(sq4[2]);
    for (int i = 0; i < 3; i++) begin
      rr[0][i] <= (RW'(sq5[i]) << (2 * FRAC_BITS + 2)) - RW'(s5);
      gg[0][i] <= -RW'(s5);
      mm[0][i] <= '0;
    end
    ss[0]  <= s5;
    ng[0]  <= neg5;
    nzz[0] <= (s5 != '0);
  end

  for (genvar t = 1; t <= SST; t++) begin : g_srch
    localparam int J = SST - t;
    logic signed [RW-1:0] cand [3];
    logic signed [RW-1:0] gnew [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = rr[t-1][i] - (gg[t-1][i] <<< (J + 2))
                  - (RW'(ss[t-1]) << (2 * J + 2));
        gnew[i] = gg[t-1][i] + (RW'(ss[t-1]) << (J + 1));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[t] <= 1'b0;
      end else begin
        vv[t] <= vv[t-1];
      end
      for (int i = 0; i < 3; i++) begin
        if (!cand[i][RW-1]) begin
          rr[t][i] <= cand[i];
          gg[t][i] <= gnew[i];
          mm[t][i] <= mm[t-1][i] | (MGW'(1) << J);
        end else begin
          rr[t][i] <= rr[t-1][i];
          gg[t][i] <= gg[t-1][i];
          mm[t][i] <= mm[t-1][i];
        end
      end
      ss[t]  <= ss[t-1];
      ng[t]  <= ng[t-1];
      nzz[t] <= nzz[t-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.valid <= 1'b0;
    end else begin
      stat.valid <= vv[SST];
    end
    stat.nonzero <= nzz[SST];
    for (int i = 0; i < 3; i++) begin
      if (!nzz[SST]) begin
        axis[i] <= '0;
      end else if (ng[SST][i]) begin
        axis[i] <= -OW'(mm[SST][i]);
      end else begin
        axis[i] <= OW'(mm[SST][i]);
      end
    end
  end

  `CHK_NOW(a_nrm_lat, clk, rst, stat.valid, $past(in_valid, LAT))
  `CHK_NOW(a_nrm_zero, clk, rst, stat.valid && !stat.nonzero,
           axis[0] == '0 && axis[1] == '0 && axis[2] == '0)
  `CHK_NOW(a_nrm_range, clk, rst, stat.valid,
           axis[0] <= LIM && axis[0] >= -LIM && axis[1] <= LIM &&
           axis[1] >= -LIM && axis[2] <= LIM && axis[2] >= -LIM)

endmodule

// File: rtl/core/orthonormal_frame_from_two_vectors.sv
// Top level of the Gram-Schmidt orthonormal frame builder.
//
//   channel  | handshake       | words
//   ---------+-----------------+------------------------------------------
//   input    | start, busy     | first_x/y/z, second_x/y/z
//   result   | done            | u/v/n_axis_x/y/z, frame_ok
//
// One word is taken every cycle; busy stays low.
// The three normalizers run in series; the bit-per-stage root search in
// each of them is FRAC_BITS + 1 stages long.
// Reset clears every valid bit; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module orthonormal_frame_from_two_vectors import ofr_pkg::*; #(
  parameter int IN_BITS   = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_BITS-1:0]   first_x,
  input  logic signed [IN_BITS-1:0]   first_y,
  input  logic signed [IN_BITS-1:0]   first_z,
  input  logic signed [IN_BITS-1:0]   second_x,
  input  logic signed [IN_BITS-1:0]   second_y,
  input  logic signed [IN_BITS-1:0]   second_z,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] u_axis_x,
  output logic signed [FRAC_BITS+1:0] u_axis_y,
  output logic signed [FRAC_BITS+1:0] u_axis_z,
  output logic signed [FRAC_BITS+1:0] v_axis_x,
  output logic signed [FRAC_BITS+1:0] v_axis_y,
  output logic signed [FRAC_BITS+1:0] v_axis_z,
  output logic signed [FRAC_BITS+1:0] n_axis_x,
  output logic signed [FRAC_BITS+1:0] n_axis_y,
  output logic signed [FRAC_BITS+1:0] n_axis_z,
  output logic                        frame_ok
);

  localparam int NL  = nrm_latency(FRAC_BITS);
  localparam int TOT = 3 * NL + 7;
  localparam int OW  = FRAC_BITS + 2;
  localparam int PW  = IN_BITS + FRAC_BITS + 2;
  localparam int DW  = IN_BITS + FRAC_BITS + 3;
  localparam int MPW = DW + FRAC_BITS + 1;
  localparam int WW  = IN_BITS + FRAC_BITS + 3;
  localparam int XW  = 2 * FRAC_BITS + 4;
  localparam int ZW  = 2 * FRAC_BITS + 5;

  logic                      accept;
  logic signed [IN_BITS-1:0] x_in [3];
  logic signed [IN_BITS-1:0] y_in [3];
  logic signed [IN_BITS-1:0] ydly [NL][3];
  logic signed [OW-1:0]      u_n [3];
  logic signed [OW-1:0]      v_n [3];
  logic signed [OW-1:0]      n_n [3];
  ofr_status_t               u_st, v_st, n_st;

  logic                      p1v, p2v, p3v, p4v, p5v;
  logic signed [IN_BITS-1:0] y1 [3];
  logic signed [IN_BITS-1:0] y2 [3];
  logic signed [IN_BITS-1:0] y3 [3];
  logic signed [IN_BITS-1:0] y4 [3];
  logic signed [OW-1:0]      u1 [3];
  logic signed [OW-1:0]      u2 [3];
  logic signed [OW-1:0]      u3 [3];
  logic signed [OW-1:0]      u4 [3];
  logic signed [OW-1:0]      u5 [3];
  logic signed [PW-1:0]      pr1 [3];
  logic signed [DW-1:0]      d2;
  logic [DW-1:0]             dmag;
  logic [FRAC_BITS:0]        umag [3];
  logic [MPW-1:0]            pm3 [3];
  logic [2:0]                s3, s4;
  logic [MPW:0]              rnd [3];
  logic [WW-1:0]             p4 [3];
  logic signed [WW-1:0]      ysh [3];
  logic signed [WW-1:0]      w5 [3];

  logic signed [OW-1:0]      udly [NL][3];
  logic                      c1v, c2v;
  logic signed [XW-1:0]      xp1 [6];
  logic signed [OW-1:0]      u6 [3];
  logic signed [OW-1:0]      v6 [3];
  logic signed [OW-1:0]      u7 [3];
  logic signed [OW-1:0]      v7 [3];
  logic signed [ZW-1:0]      z7 [3];
  logic signed [OW-1:0]      uod [NL][3];
  logic signed [OW-1:0]      vod [NL][3];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    x_in[0] = first_x;
    x_in[1] = first_y;
    x_in[2] = first_z;
    y_in[0] = second_x;
    y_in[1] = second_y;
    y_in[2] = second_z;
  end

  ofr_normalize #(.IW(IN_BITS), .FRAC_BITS(FRAC_BITS)) u_nrm_u (
    .clk(clk), .rst(rst), .in_valid(accept), .vec(x_in), .axis(u_n), .stat(u_st)
  );

  always_ff @(posedge clk) begin
    ydly[0] <= y_in;
    for (int k = 1; k < NL; k++) begin
      ydly[k] <= ydly[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      umag[i] = (u2[i][OW-1]) ? FRAC_BITS'(0) + (FRAC_BITS+1)'(-u2[i])
                              : (FRAC_BITS+1)'(u2[i]);
      rnd[i]  = {1'b0, pm3[i]} + ((MPW+1)'(1) << (FRAC_BITS - 1));
      ysh[i]  = WW'(y4[i]) <<< FRAC_BITS;
    end
    dmag = d2[DW-1] ? DW'(-d2) : DW'(d2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
      p4v <= 1'b0;
      p5v <= 1'b0;
    end else begin
      p1v <= u_st.valid;
      p2v <= p1v;
      p3v <= p2v;
      p4v <= p3v;
      p5v <= p4v;
    end
    for (int i = 0; i < 3; i++) begin
      pr1[i] <= PW'(ydly[NL-1][i]) * PW'(u_n[i]);
      pm3[i] <= MPW'(dmag) * MPW'(umag[i]);
      s3[i]  <= d2[DW-1] ^ u2[i][OW-1];
      p4[i]  <= WW'(rnd[i] >> FRAC_BITS);
      w5[i]  <= s4[i] ? ysh[i] + $signed(p4[i]) : ysh[i] - $signed(p4[i]);
    end
    d2 <= DW'(pr1[0]) + DW'(pr1[1]) + DW'(pr1[2]);
    s4 <= s3;
    y1 <= ydly[NL-1];
    y2 <= y1;
    y3 <= y2;
    y4 <= y3;
    u1 <= u_n;
    u2 <= u1;
    u3 <= u2;
    u4 <= u3;
    u5 <= u4;
  end

  ofr_normalize #(.IW(WW), .FRAC_BITS(FRAC_BITS)) u_nrm_v (
    .clk(clk), .rst(rst), .in_valid(p5v), .vec(w5), .axis(v_n), .stat(v_st)
  );

  always_ff @(posedge clk) begin
    udly[0] <= u5;
    for (int k = 1; k < NL; k++) begin
      udly[k] <= udly[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1v <= 1'b0;
      c2v <= 1'b0;
    end else begin
      c1v <= v_st.valid;
      c2v <= c1v;
    end
    xp1[0] <= XW'(udly[NL-1][1]) * XW'(v_n[2]);
    xp1[1] <= XW'(udly[NL-1][2]) * XW'(v_n[1]);
    xp1[2] <= XW'(udly[NL-1][2]) * XW'(v_n[0]);
    xp1[3] <= XW'(udly[NL-1][0]) * XW'(v_n[2]);
    xp1[4] <= XW'(udly[NL-1][0]) * XW'(v_n[1]);
    xp1[5] <= XW'(udly[NL-1][1]) * XW'(v_n[0]);
    u6 <= udly[NL-1];
    v6 <= v_n;
    z7[0] <= ZW'(xp1[0]) - ZW'(xp1[1]);
    z7[1] <= ZW'(xp1[2]) - ZW'(xp1[3]);
    z7[2] <= ZW'(xp1[4]) - ZW'(xp1[5]);
    u7 <= u6;
    v7 <= v6;
  end

  ofr_normalize #(.IW(ZW), .FRAC_BITS(FRAC_BITS)) u_nrm_n (
    .clk(clk), .rst(rst), .in_valid(c2v), .vec(z7), .axis(n_n), .stat(n_st)
  );

  always_ff @(posedge clk) begin
    uod[0] <= u7;
    vod[0] <= v7;
    for (int k = 1; k < NL; k++) begin
      uod[k] <= uod[k-1];
      vod[k] <= vod[k-1];
    end
  end

  assign done     = n_st.valid;
  assign frame_ok = n_st.nonzero;
  assign u_axis_x = uod[NL-1][0];
  assign u_axis_y = uod[NL-1][1];
  assign u_axis_z = uod[NL-1][2];
  assign v_axis_x = vod[NL-1][0];
  assign v_axis_y = vod[NL-1][1];
  assign v_axis_z = vod[NL-1][2];
  assign n_axis_x = n_n[0];
  assign n_axis_y = n_n[1];
  assign n_axis_z = n_n[2];

  `CHK_NOW(a_top_lat, clk, rst, done, $past(start, TOT))
  `CHK_NOW(a_top_ok, clk, rst, done && frame_ok,
           (u_axis_x != '0 || u_axis_y != '0 || u_axis_z != '0) &&
           (v_axis_x != '0 || v_axis_y != '0 || v_axis_z != '0))
  `CHK_NOW(a_top_flat, clk, rst, done && !frame_ok,
           n_axis_x == '0 && n_axis_y == '0 && n_axis_z == '0)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the Gram-Schmidt orthonormal frame builder.
module tb_top;

  localparam int IN_BITS   = 24;
  localparam int FRAC_BITS = 16;
  localparam int OW        = FRAC_BITS + 2;
  localparam int LATENCY   = 3 * (FRAC_BITS + 8) + 7;
  localparam int N_RANDOM  = 1050;

  typedef struct {
    logic signed [IN_BITS-1:0] a[3];
    logic signed [IN_BITS-1:0] b[3];
  } vec_pair_t;

  typedef struct {
    logic signed [OW-1:0] u[3];
    logic signed [OW-1:0] v[3];
    logic signed [OW-1:0] n[3];
    logic                 ok;
  } frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_BITS-1:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [IN_BITS-1:0] second_x = '0, second_y = '0, second_z = '0;
  logic done;
  logic signed [OW-1:0] u_axis_x, u_axis_y, u_axis_z;
  logic signed [OW-1:0] v_axis_x, v_axis_y, v_axis_z;
  logic signed [OW-1:0] n_axis_x, n_axis_y, n_axis_z;
  logic frame_ok;

  vec_pair_t pending_pairs[$];
  frame_t    expected_frames[$];
  int        n_sent = 0, n_checked = 0, n_flat = 0, n_errors = 0;
  int        sender_idle_pct = 12;

  orthonormal_frame_from_two_vectors #(.IN_BITS(IN_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .done(done),
    .u_axis_x(u_axis_x), .u_axis_y(u_axis_y), .u_axis_z(u_axis_z),
    .v_axis_x(v_axis_x), .v_axis_y(v_axis_y), .v_axis_z(v_axis_z),
    .n_axis_x(n_axis_x), .n_axis_y(n_axis_y), .n_axis_z(n_axis_z),
    .frame_ok(frame_ok)
  );

  always #4 clk = ~clk;

  function automatic bit scale_to_unit(input longint c[3], output longint o[3]);
    logic [63:0]  mag[3];
    logic [63:0]  mx, s, lo, hi, mid, t;
    logic [127:0] lhs, rhs;
    int           k;
    mx = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] = mag[i] >> k;
      s += mag[i] * mag[i];
    end
    if (s == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b0;
    end
    for (int i = 0; i < 3; i++) begin
      lo = 0;
      hi = 64'd1 << FRAC_BITS;
      rhs = {64'd0, mag[i] * mag[i]} << (2 * FRAC_BITS + 2);
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t = 2 * mid - 1;
        lhs = {64'd0, t * t} * {64'd0, s};
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      o[i] = c[i] < 0 ? -longint'(lo) : longint'(lo);
    end
    return 1'b1;
  endfunction

  function automatic frame_t predict_frame(input vec_pair_t p);
    frame_t       f;
    longint       x[3], y[3], u[3], w[3], v[3], z[3], n[3];
    longint       d, pr;
    logic [127:0] prod;
    for (int i = 0; i < 3; i++) begin
      x[i] = p.a[i];
      y[i] = p.b[i];
    end
    void'(scale_to_unit(x, u));
    d = 0;
    for (int i = 0; i < 3; i++) d += y[i] * u[i];
    for (int i = 0; i < 3; i++) begin
      prod = {64'd0, 64'(d < 0 ? -d : d)} * {64'd0, 64'(u[i] < 0 ? -u[i] : u[i])};
      prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      pr = longint'(prod[63:0]);
      if ((d < 0) != (u[i] < 0)) pr = -pr;
      w[i] = y[i] * (longint'(1) << FRAC_BITS) - pr;
    end
    void'(scale_to_unit(w, v));
    z[0] = u[1] * v[2] - u[2] * v[1];
    z[1] = u[2] * v[0] - u[0] * v[2];
    z[2] = u[0] * v[1] - u[1] * v[0];
    f.ok = scale_to_unit(z, n);
    for (int i = 0; i < 3; i++) begin
      f.u[i] = OW'(u[i]);
      f.v[i] = OW'(v[i]);
      f.n[i] = OW'(n[i]);
    end
    return f;
  endfunction

  function automatic void queue_pair(input longint a0, a1, a2, b0, b1, b2);
    vec_pair_t p;
    p.a[0] = IN_BITS'(a0);
    p.a[1] = IN_BITS'(a1);
    p.a[2] = IN_BITS'(a2);
    p.b[0] = IN_BITS'(b0);
    p.b[1] = IN_BITS'(b1);
    p.b[2] = IN_BITS'(b2);
    pending_pairs.push_back(p);
  endfunction

  function automatic longint rand_comp(input int kind);
    case (kind)
      0: return longint'($urandom_range(200)) - 100;
      1: return longint'($urandom_range(1 << 16)) - (1 << 15);
      default: return longint'(signed'(IN_BITS'($urandom)));
    endcase
  endfunction

  // Driver: record each accepted word, then present the next or drop start.
  always @(posedge clk) begin
    vec_pair_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nxt.a[0] = first_x;
        nxt.a[1] = first_y;
        nxt.a[2] = first_z;
        nxt.b[0] = second_x;
        nxt.b[1] = second_y;
        nxt.b[2] = second_z;
        expected_frames.push_back(predict_frame(nxt));
        n_sent++;
        if (n_sent > 350) sender_idle_pct = 53;
        if (n_sent > 700) sender_idle_pct = 0;
      end
      if ((!start || !busy) && pending_pairs.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
        nxt = pending_pairs.pop_front();
        first_x <= nxt.a[0];
        first_y <= nxt.a[1];
        first_z <= nxt.a[2];
        second_x <= nxt.b[0];
        second_y <= nxt.b[1];
        second_z <= nxt.b[2];
        start <= 1'b1;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare every result word with the oldest prediction.
  always @(posedge clk) begin
    frame_t e;
    frame_t g;
    if (!rst && done) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result word", $time);
        n_errors++;
      end else begin
        e = expected_frames.pop_front();
        g.u[0] = u_axis_x; g.u[1] = u_axis_y; g.u[2] = u_axis_z;
        g.v[0] = v_axis_x; g.v[1] = v_axis_y; g.v[2] = v_axis_z;
        g.n[0] = n_axis_x; g.n[1] = n_axis_y; g.n[2] = n_axis_z;
        g.ok = frame_ok;
        for (int i = 0; i < 3; i++) begin
          if (g.u[i] !== e.u[i]) begin
            $display("%0t: u axis[%0d] expected %0d got %0d", $time, i, e.u[i], g.u[i]);
            n_errors++;
          end
          if (g.v[i] !== e.v[i]) begin
            $display("%0t: v axis[%0d] expected %0d got %0d", $time, i, e.v[i], g.v[i]);
            n_errors++;
          end
          if (g.n[i] !== e.n[i]) begin
            $display("%0t: n axis[%0d] expected %0d got %0d", $time, i, e.n[i], g.n[i]);
            n_errors++;
          end
        end
        if (g.ok !== e.ok) begin
          $display("%0t: frame_ok expected %0b got %0b", $time, e.ok, g.ok);
          n_errors++;
        end
        if (!e.ok) n_flat++;
        n_checked++;
      end
    end
  end

  initial begin
    longint mx, mn, a0, a1, a2, s;
    int     kind, sel;
    mx = (longint'(1) << (IN_BITS - 1)) - 1;
    mn = -(longint'(1) << (IN_BITS - 1));
    queue_pair(0, 0, 0, 0, 0, 0);
    queue_pair(0, 0, 0, 3, -4, 5);
    queue_pair(1, 2, 3, 0, 0, 0);
    queue_pair(1, 0, 0, 0, 1, 0);
    queue_pair(mx, mx, mx, mn, mn, mn);
    queue_pair(mn, mn, mn, mx, 0, mn);
    queue_pair(mn, 0, 0, 0, mn, 0);
    queue_pair(mx, mn, mx, mn, mx, mn);
    queue_pair(2, 4, 6, -1, -2, -3);
    queue_pair(5, -7, 9, 10, -14, 18);
    queue_pair(mx, 1, -1, 1, mx, mn);
    queue_pair(-1, -1, -1, 1, -1, 1);
    queue_pair(3, 4, 0, 4, -3, 0);
    queue_pair(0, 0, mn, mx, mx, 0);
    queue_pair(1, 1, 0, 1, 0, 1);
    queue_pair(-1, 0, 0, 1, 1, 0);
    queue_pair(mx, mx, 0, mx, mx, 1);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(2);
      sel = $urandom_range(99);
      a0 = rand_comp(kind);
      a1 = rand_comp(kind);
      a2 = rand_comp(kind);
      if (sel < 10) begin
        s = longint'($urandom_range(8)) - 4;
        if (kind == 2) s = $urandom_range(1) ? 1 : -1;
        if (s == 0 || (s == -1 && (a0 == mn || a1 == mn || a2 == mn))) s = 1;
        if (kind == 2) queue_pair(a0, a1, a2, s * a0, s * a1, s * a2);
        else queue_pair(a0, a1, a2, s * a0, s * a1, s * a2);
      end else if (sel < 14) begin
        queue_pair(0, 0, 0, rand_comp(kind), rand_comp(kind), rand_comp(kind));
      end else if (sel < 18) begin
        queue_pair(a0, a1, a2, 0, 0, 0);
      end else begin
        queue_pair(a0, a1, a2, rand_comp($urandom_range(2)), rand_comp($urandom_range(2)),
                   rand_comp($urandom_range(2)));
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && !start);
    wait (expected_frames.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Checked %0d frames from %0d word pairs, %0d of them degenerate.",
             n_checked, n_sent, n_flat);
    if (n_errors == 0 && expected_frames.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
